@@ hw/rtl/aphc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playhead crossfade package
// Shared constants, request codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aphc_pkg;

  // Default sizes of the fixed point fields.
  localparam int TIME_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ID_BITS_DEF   = 8;

  // Rates are Q4.12 on a 16 bit register.
  localparam int RATE_FRAC = 12;
  localparam int RATE_W    = 16;
  localparam int REQ_W     = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUEUE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SEEK  = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_PLAY_RATE = 1'b0;
  localparam logic CFG_LOOP_MODE = 1'b1;

  // Divider operand select.
  localparam logic SEL_CUR = 1'b0;
  localparam logic SEL_NXT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CUR_START,
    ST_CUR_DIV,
    ST_NXT_START,
    ST_NXT_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_start;
    logic div_sel;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/animation_playhead_crossfade_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playhead crossfade core
// Keeps the playhead of a current and a crossfading next sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request code and
//   s_tdata the delta or seek time, sequence length, id and blend rate.
//   Every request yields one status transfer on the m_ stream.
//   Tick and seek requests pass through the restoring modulo unit that is
//   shared by the current and the next playhead, one bit a cycle; other
//   requests skip it. One request is in flight at a time; the next one is
//   accepted once the core returns to idle after its commit step. The result
//   sits in an output register; a stalled receiver holds the core in its
//   commit step until the pending transfer completes.
//   Synchronous reset clears all playheads and flags and sets play_rate to one
//   and loop_mode to clamp. The user must write configuration through cfg_wr_en,
//   cfg_addr and cfg_wdata only while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module animation_playhead_crossfade_core import aphc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  localparam int IN_RAW   = (TIME_BITS + 1) + TIME_BITS + ID_BITS + RATE_W,
  localparam int IN_W     = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW  = 2 * TIME_BITS + FRAC_BITS + 1 + ID_BITS + 2,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_addr,
  input  logic [RATE_W-1:0]  cfg_wdata,
  input  logic               s_tvalid,
  output logic               s_tready,
  // time_value, seq_length, seq_id, blend_rate
  input  logic [IN_W-1:0]    s_tdata,
  // req_type
  input  logic [REQ_W-1:0]   s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // current_time, next_time, blend_weight, active_id, is_playing, is_blending
  output logic [OUT_W-1:0]   m_tdata
);

  localparam int TB = TIME_BITS;

  cmd_t cmd;
  sts_t sts;

  logic [TB-1:0]      o_cur, o_nxt;
  logic [FRAC_BITS:0] o_blend;
  logic [ID_BITS-1:0] o_id;
  logic               o_play, o_fade;

  aphc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aphc_dp #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_req    (s_tuser),
    .in_tv     (s_tdata[TB:0]),
    .in_len    (s_tdata[TB+1 +: TB]),
    .in_id     (s_tdata[2*TB+1 +: ID_BITS]),
    .in_brate  (s_tdata[2*TB+1+ID_BITS +: RATE_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_cur   (o_cur),
    .out_nxt   (o_nxt),
    .out_blend (o_blend),
    .out_id    (o_id),
    .out_play  (o_play),
    .out_fade  (o_fade)
  );

  // Pack the result fields, lowest first, padded to whole bytes.
  assign m_tdata = {{(OUT_W-OUT_RAW){1'b0}}, o_fade, o_play, o_id, o_blend, o_nxt, o_cur};

endmodule

@@ hw/rtl/aphc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playhead controller
// Sequences one request through multiply, sum, two modulo passes for ticks and seeks, and commit.
// ----------------------------------------------------------------------------
module aphc_ctrl import aphc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL;
      ST_MUL:       state_next = ST_SUM;
      ST_SUM:       state_next = sts.need_div ? ST_CUR_START : ST_COMMIT;
      ST_CUR_START: state_next = ST_CUR_DIV;
      ST_CUR_DIV:   if (sts.div_done) state_next = ST_NXT_START;
      ST_NXT_START: state_next = ST_NXT_DIV;
      ST_NXT_DIV:   if (sts.div_done) state_next = ST_COMMIT;
      ST_COMMIT:    if (!sts.out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:       cmd.mul = 1'b1;
      ST_SUM:       cmd.sum = 1'b1;
      ST_CUR_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_CUR;
      end
      ST_CUR_DIV:   cmd.div_step = 1'b1;
      ST_NXT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_NXT;
      end
      ST_NXT_DIV:   cmd.div_step = 1'b1;
      ST_COMMIT:    cmd.commit = !sts.out_busy;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/aphc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playhead datapath
// Holds configuration and playhead state, the rate multipliers, a shared
// restoring modulo unit and the output register.
// ----------------------------------------------------------------------------
module aphc_dp import aphc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_addr,
  input  logic [RATE_W-1:0]             cfg_wdata,
  input  logic [REQ_W-1:0]              in_req,
  input  logic signed [TIME_BITS:0]     in_tv,
  input  logic [TIME_BITS-1:0]          in_len,
  input  logic [ID_BITS-1:0]            in_id,
  input  logic [RATE_W-1:0]             in_brate,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [TIME_BITS-1:0]          out_cur,
  output logic [TIME_BITS-1:0]          out_nxt,
  output logic [FRAC_BITS:0]            out_blend,
  output logic [ID_BITS-1:0]            out_id,
  output logic                          out_play,
  output logic                          out_fade
);

  localparam int TB  = TIME_BITS;
  localparam int PW  = TB + 1 + RATE_W;        // delta * play_rate
  localparam int AW  = PW - RATE_FRAC;         // advance
  localparam int PW2 = TB + 2 + RATE_W;        // delta * fade speed
  localparam int SPW = PW2 - RATE_FRAC;        // blend step
  localparam int SW  = AW + 1;                 // time sums
  localparam int BW  = SPW + 1;                // blend sum
  localparam int BLW = FRAC_BITS + 1;
  localparam int CW  = $clog2(SW);
  localparam logic [BW-1:0] BONE = {{(BW-BLW){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Configuration.
  logic signed [RATE_W-1:0] play_rate;
  logic                     loop_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_rate <= RATE_W'(4096);
      loop_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_PLAY_RATE: play_rate <= cfg_wdata;
        CFG_LOOP_MODE: loop_mode <= cfg_wdata[0];
        default:       loop_mode <= loop_mode;
      endcase
    end
  end

  // Playhead state.
  logic [TB-1:0]      cur_time, nxt_time, cur_len, nxt_len;
  logic [BLW-1:0]     blend_acc;
  logic [RATE_W-1:0]  fade_speed;
  logic [ID_BITS-1:0] cur_ident, nxt_ident;
  logic               f_cur, f_nxt, f_play;

  // Latched request.
  logic [REQ_W-1:0]   req_r;
  logic signed [TB:0] tv_r;
  logic [TB-1:0]      len_r;
  logic [ID_BITS-1:0] id_r;
  logic [RATE_W-1:0]  brate_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      tv_r    <= in_tv;
      len_r   <= in_len;
      id_r    <= in_id;
      brate_r <= in_brate;
    end
  end

  // Multiply stage: floor of the products scaled down by the rate fraction.
  logic signed [PW-1:0]  prod_adv;
  logic signed [PW2-1:0] prod_step;
  logic signed [AW-1:0]  adv_r;
  logic signed [SPW-1:0] step_r;

  assign prod_adv  = tv_r * play_rate;
  assign prod_step = tv_r * $signed({1'b0, fade_speed});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      adv_r  <= prod_adv[RATE_FRAC +: AW];
      step_r <= prod_step[RATE_FRAC +: SPW];
    end
  end

  // Sum stage: exact sums before any wrap or clamp.
  logic signed [SW-1:0] tcur_r, tnxt_r, tseek;
  logic signed [BW-1:0] bsum_r;

  assign tseek = {{(SW-TB-1){tv_r[TB]}}, tv_r};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      tcur_r <= $signed({{(SW-TB){1'b0}}, cur_time}) + $signed({adv_r[AW-1], adv_r});
      tnxt_r <= $signed({{(SW-TB){1'b0}}, nxt_time}) + $signed({adv_r[AW-1], adv_r});
      bsum_r <= $signed({{(BW-BLW){1'b0}}, blend_acc}) + $signed({step_r[SPW-1], step_r});
    end
  end

  // Shared restoring modulo unit, one quotient bit per cycle.
  logic [SW-1:0]   mag;
  logic [TB:0]     rem;
  logic [TB-1:0]   dlen;
  logic            dneg, dsel;
  logic [CW-1:0]   cnt;
  logic [TB-1:0]   wrap_cur, wrap_nxt;
  logic signed [SW-1:0] dop;
  logic [TB:0]     rshift, rem_new;
  logic [TB-1:0]   wrap_res;

  assign dop     = (req_r == REQ_SEEK) ? tseek : ((cmd.div_sel == SEL_CUR) ? tcur_r : tnxt_r);
  assign rshift  = {rem[TB-1:0], mag[SW-1]};
  assign rem_new = (rshift >= {1'b0, dlen}) ? rshift - {1'b0, dlen} : rshift;
  assign wrap_res = (dneg && (rem_new != '0)) ? dlen - rem_new[TB-1:0] : rem_new[TB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      mag  <= dop[SW-1] ? SW'(-dop) : SW'(dop);
      dneg <= dop[SW-1];
      rem  <= '0;
      cnt  <= '0;
      dsel <= cmd.div_sel;
      dlen <= (cmd.div_sel == SEL_CUR) ? cur_len : nxt_len;
    end else if (cmd.div_step) begin
      mag <= {mag[SW-2:0], 1'b0};
      rem <= rem_new;
      cnt <= cnt + CW'(1);
      if (cnt == CW'(SW-1)) begin
        if (dsel == SEL_CUR) wrap_cur <= wrap_res;
        else wrap_nxt <= wrap_res;
      end
    end
  end

  assign sts.need_div = (req_r == REQ_TICK) || (req_r == REQ_SEEK);
  assign sts.div_done = cmd.div_step && (cnt == CW'(SW-1));
  assign sts.out_busy = out_valid && !out_ready;

  // Clamp a signed time into the range from zero to the length.
  function automatic logic [TB-1:0] clamp_t(input logic signed [SW-1:0] t,
                                            input logic [TB-1:0] len);
    if (t < 0) return '0;
    if (t > $signed({{(SW-TB){1'b0}}, len})) return len;
    return t[TB-1:0];
  endfunction

  // Next state of the playhead, per request.
  logic [TB-1:0]      cur_time_next, nxt_time_next, cur_len_next, nxt_len_next;
  logic [BLW-1:0]     blend_acc_next;
  logic [RATE_W-1:0]  fade_speed_next;
  logic [ID_BITS-1:0] cur_ident_next, nxt_ident_next;
  logic               f_cur_next, f_nxt_next, f_play_next;
  logic [TB-1:0]      ct, nt;
  logic [BLW-1:0]     bc;

  always_comb begin
    cur_time_next   = cur_time;
    nxt_time_next   = nxt_time;
    cur_len_next    = cur_len;
    nxt_len_next    = nxt_len;
    blend_acc_next  = blend_acc;
    fade_speed_next = fade_speed;
    cur_ident_next  = cur_ident;
    nxt_ident_next  = nxt_ident;
    f_cur_next      = f_cur;
    f_nxt_next      = f_nxt;
    f_play_next     = f_play;
    ct = '0;
    nt = '0;
    bc = '0;
    unique case (req_r)
      REQ_TICK: begin
        if (f_play && f_cur) begin
          if (loop_mode && (cur_len != '0)) begin
            ct = wrap_cur;
          end else begin
            ct = clamp_t(tcur_r, cur_len);
            if ((!play_rate[RATE_W-1] && (ct >= cur_len)) ||
                (play_rate[RATE_W-1] && (ct == '0)))
              f_play_next = 1'b0;
          end
          cur_time_next = ct;
          if (f_nxt) begin
            nt = (nxt_len != '0) ? wrap_nxt : '0;
            if (bsum_r < 0) bc = '0;
            else if (bsum_r >= $signed(BONE)) bc = BONE[BLW-1:0];
            else bc = bsum_r[BLW-1:0];
            if (bc == BONE[BLW-1:0]) begin
              cur_ident_next = nxt_ident;
              cur_len_next   = nxt_len;
              cur_time_next  = nt;
              f_nxt_next     = 1'b0;
              nxt_time_next  = '0;
              blend_acc_next = '0;
            end else begin
              nxt_time_next  = nt;
              blend_acc_next = bc;
            end
          end
        end
      end
      REQ_START: begin
        cur_ident_next = id_r;
        cur_len_next   = len_r;
        cur_time_next  = '0;
        f_cur_next     = 1'b1;
        f_play_next    = 1'b1;
        f_nxt_next     = 1'b0;
        nxt_time_next  = '0;
        blend_acc_next = '0;
      end
      REQ_QUEUE: begin
        if (!(f_cur && (id_r == cur_ident))) begin
          nxt_ident_next  = id_r;
          nxt_len_next    = len_r;
          nxt_time_next   = '0;
          blend_acc_next  = '0;
          fade_speed_next = brate_r;
          f_nxt_next      = 1'b1;
        end
      end
      REQ_PLAY:  if (f_cur) f_play_next = 1'b1;
      REQ_PAUSE: f_play_next = 1'b0;
      REQ_STOP: begin
        cur_time_next  = '0;
        nxt_time_next  = '0;
        blend_acc_next = '0;
        f_nxt_next     = 1'b0;
        f_play_next    = 1'b0;
      end
      REQ_SEEK: begin
        if (f_cur && (cur_len != '0))
          cur_time_next = loop_mode ? wrap_cur : clamp_t(tseek, cur_len);
        else
          cur_time_next = '0;
        if (f_nxt && (nxt_len != '0))
          nxt_time_next = loop_mode ? wrap_nxt : clamp_t(tseek, nxt_len);
        else
          nxt_time_next = '0;
      end
      default: f_play_next = f_play;
    endcase
  end

  // State update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time   <= '0;
      nxt_time   <= '0;
      cur_len    <= '0;
      nxt_len    <= '0;
      blend_acc  <= '0;
      fade_speed <= '0;
      cur_ident  <= '0;
      nxt_ident  <= '0;
      f_cur      <= 1'b0;
      f_nxt      <= 1'b0;
      f_play     <= 1'b0;
    end else if (cmd.commit) begin
      cur_time   <= cur_time_next;
      nxt_time   <= nxt_time_next;
      cur_len    <= cur_len_next;
      nxt_len    <= nxt_len_next;
      blend_acc  <= blend_acc_next;
      fade_speed <= fade_speed_next;
      cur_ident  <= cur_ident_next;
      nxt_ident  <= nxt_ident_next;
      f_cur      <= f_cur_next;
      f_nxt      <= f_nxt_next;
      f_play     <= f_play_next;
    end
  end

  // Output register, held until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_cur   <= cur_time_next;
      out_nxt   <= nxt_time_next;
      out_blend <= blend_acc_next;
      out_id    <= cur_ident_next;
      out_play  <= f_play_next;
      out_fade  <= f_nxt_next;
    end
  end

endmodule

@@ test/animation_playhead_crossfade_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animation playhead crossfade core test
// Drives requests on the input stream and checks every status transfer
// against a behavioral playhead model or a typed table row. Directed requests
// come first, followed by random sessions under several rate and loop settings.
// ----------------------------------------------------------------------------
module animation_playhead_crossfade_core_test import aphc_pkg::*; ();

  localparam int TB = 24;
  localparam int IN_W = 80;
  localparam int OUT_W = 80;
  localparam int OUT_RAW_BITS = 2 * TB + 17 + 8 + 2;
  localparam int WATCH_LIMIT = 20000;

  // Lowest field last, so the layout matches m_tdata.
  typedef struct packed {
    logic        blending;
    logic        playing;
    logic [7:0]  ident;
    logic [16:0] weight;
    logic [23:0] nxt;
    logic [23:0] cur;
  } status_t;

  typedef struct {
    logic [2:0]  req;
    logic [24:0] tval;
    logic [23:0] len;
    logic [7:0]  id;
    logic [15:0] brate;
  } request_t;

  typedef struct {
    request_t rq;
    bit       typed;
    status_t  st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  animation_playhead_crossfade_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Model state of the playheads.
  longint rate_q;
  bit loop_q;
  longint c_time, n_time, c_len, n_len, weight_q, fade_q;
  logic [7:0] c_id, n_id;
  bit has_cur, has_nxt, playing_q;

  status_t status_q[$];
  int mismatches = 0;
  bit failed = 0;
  int watch = 0;

  function automatic longint floor_div4k(longint v);
    return v >>> RATE_FRAC;
  endfunction

  function automatic longint wrap_t(longint t, longint len);
    longint r;
    r = t % len;
    if (r < 0) r += len;
    return r;
  endfunction

  function automatic longint clamp_t(longint t, longint len);
    if (t < 0) return 0;
    if (t > len) return len;
    return t;
  endfunction

  function automatic longint seek_t(longint t, bit present, longint len);
    if (!present || len == 0) return 0;
    return loop_q ? wrap_t(t, len) : clamp_t(t, len);
  endfunction

  // Advances the model by one request and returns the status it reports.
  function automatic status_t playhead_next(request_t rq);
    longint tv, adv, t, b;
    status_t s;
    tv = longint'(signed'(rq.tval));
    case (rq.req)
      REQ_TICK: begin
        if (playing_q && has_cur) begin
          adv = floor_div4k(tv * rate_q);
          t = c_time + adv;
          if (loop_q && c_len > 0) begin
            c_time = wrap_t(t, c_len);
          end else begin
            c_time = clamp_t(t, c_len);
            if ((rate_q >= 0 && c_time >= c_len) || (rate_q < 0 && c_time == 0))
              playing_q = 0;
          end
          if (has_nxt) begin
            t = n_time + adv;
            n_time = (n_len > 0) ? wrap_t(t, n_len) : 0;
            b = weight_q + floor_div4k(tv * fade_q);
            if (b < 0) b = 0;
            if (b > 65536) b = 65536;
            weight_q = b;
            if (weight_q >= 65536) begin
              c_id = n_id;
              c_len = n_len;
              c_time = n_time;
              has_nxt = 0;
              n_time = 0;
              weight_q = 0;
            end
          end
        end
      end
      REQ_START: begin
        c_id = rq.id;
        c_len = rq.len;
        c_time = 0;
        has_cur = 1;
        playing_q = 1;
        has_nxt = 0;
        n_time = 0;
        weight_q = 0;
      end
      REQ_QUEUE: begin
        if (!(has_cur && rq.id == c_id)) begin
          n_id = rq.id;
          n_len = rq.len;
          n_time = 0;
          weight_q = 0;
          fade_q = rq.brate;
          has_nxt = 1;
        end
      end
      REQ_PLAY: if (has_cur) playing_q = 1;
      REQ_PAUSE: playing_q = 0;
      REQ_STOP: begin
        c_time = 0;
        n_time = 0;
        weight_q = 0;
        has_nxt = 0;
        playing_q = 0;
      end
      REQ_SEEK: begin
        c_time = seek_t(tv, has_cur, c_len);
        n_time = seek_t(tv, has_nxt, n_len);
      end
      default: ;
    endcase
    s.cur = c_time[23:0];
    s.nxt = n_time[23:0];
    s.weight = weight_q[16:0];
    s.ident = c_id;
    s.playing = playing_q;
    s.blending = has_nxt;
    return s;
  endfunction

  function automatic request_t mk(logic [2:0] r, logic [24:0] tv, logic [23:0] ln,
                                  logic [7:0] id, logic [15:0] br);
    request_t q;
    q.req = r; q.tval = tv; q.len = ln; q.id = id; q.brate = br;
    return q;
  endfunction

  function automatic status_t st_of(logic [23:0] c, logic [23:0] n, logic [16:0] w,
                                    logic [7:0] id, bit p, bit b);
    status_t s;
    s.cur = c; s.nxt = n; s.weight = w; s.ident = id; s.playing = p; s.blending = b;
    return s;
  endfunction

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // Sends one request; the expected status is queued at the accepting edge.
  task automatic send_request(request_t rq, bit typed, status_t st);
    status_t exp_s;
    repeat (gap_len()) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= rq.req;
    s_tdata <= {7'd0, rq.brate, rq.id, rq.len, rq.tval};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_s = playhead_next(rq);
    if (typed) exp_s = st;
    status_q.push_back(exp_s);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (status_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_PLAY_RATE) rate_q = longint'(signed'(val));
    else loop_q = val[0];
    @(posedge clk);
  endtask

  // Receiver side: random stalls and checking of each status transfer.
  initial begin
    status_t got, want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_RAW_BITS-1:0];
        if (status_q.size() == 0) begin
          failed = 1;
          if (mismatches < 10) $display("unexpected status transfer %h", got);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            failed = 1;
            if (mismatches < 10)
              $display({"status mismatch: expected cur=%h nxt=%h w=%h id=%h p=%b b=%b,",
                        " got cur=%h nxt=%h w=%h id=%h p=%b b=%b"},
                       want.cur, want.nxt, want.weight, want.ident, want.playing,
                       want.blending, got.cur, got.nxt, got.weight, got.ident,
                       got.playing, got.blending);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 && gap_len() == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watch = 0;
      else watch++;
      if (watch >= WATCH_LIMIT) begin
        $display("animation_playhead_crossfade_core test failed");
        $finish;
      end
    end
  end

  function automatic request_t rand_request(bit well_formed, logic [7:0] pool);
    request_t q;
    int r;
    q.tval = 25'($urandom);
    q.brate = 16'($urandom);
    q.id = $urandom_range(0, 99) < 80 ? 8'($urandom_range(0, pool)) : 8'($urandom);
    r = $urandom_range(0, 9);
    q.len = r < 2 ? 24'($urandom) : (r < 3 ? 24'd0 : 24'($urandom_range(1, 500000)));
    if (!well_formed) begin
      q.req = 3'($urandom);
      return q;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      q.req = REQ_TICK;
      if ($urandom_range(0, 9) < 8) q.tval = 25'(signed'($urandom_range(0, 4000)) - 500);
    end else if (r < 68) q.req = REQ_START;
    else if (r < 78) begin
      q.req = REQ_QUEUE;
      if ($urandom_range(0, 3) != 0) q.brate = 16'($urandom_range(0, 40000));
    end else if (r < 84) q.req = REQ_PLAY;
    else if (r < 88) q.req = REQ_PAUSE;
    else if (r < 91) q.req = REQ_STOP;
    else q.req = REQ_SEEK;
    return q;
  endfunction

  row_t dir_rows[$];

  initial begin
    status_t none;
    request_t rq;
    logic [15:0] rates[6];
    none = '0;
    rate_q = 4096; loop_q = 0;
    c_time = 0; n_time = 0; c_len = 0; n_len = 0; weight_q = 0; fade_q = 0;
    c_id = 0; n_id = 0; has_cur = 0; has_nxt = 0; playing_q = 0;
    rates = '{16'h1000, 16'h7fff, 16'h8000, 16'hf000, 16'h0000, 16'h0800};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; rows are typed where the status is obvious.
    dir_rows.push_back('{mk(REQ_TICK, 25'd1000, 0, 0, 0), 1, st_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(REQ_PLAY, 0, 0, 0, 0), 1, st_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(REQ_QUEUE, 0, 24'd100, 8'd5, 16'd4096), 1,
                         st_of(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{mk(REQ_TICK, 25'd50, 0, 0, 0), 1, st_of(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{mk(REQ_SEEK, 25'd70, 0, 0, 0), 1, st_of(0, 70, 0, 0, 0, 1)});
    dir_rows.push_back('{mk(REQ_START, 0, 24'hffffff, 8'hff, 0), 1,
                         st_of(0, 0, 0, 8'hff, 1, 0)});
    dir_rows.push_back('{mk(REQ_QUEUE, 0, 24'd1000, 8'hff, 16'hffff), 1,
                         st_of(0, 0, 0, 8'hff, 1, 0)});
    dir_rows.push_back('{mk(REQ_TICK, 25'h0ffffff, 0, 0, 0), 0, none});
    // The tick above reached the end and stopped playback.
    dir_rows.push_back('{mk(REQ_SEEK, 25'h1000000, 0, 0, 0), 1,
                         st_of(0, 0, 0, 8'hff, 0, 0)});
    dir_rows.push_back('{mk(REQ_QUEUE, 0, 24'd0, 8'd1, 16'd65535), 0, none});
    dir_rows.push_back('{mk(REQ_TICK, 25'd2000, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_TICK, 25'd70000, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_START, 0, 24'd0, 8'd3, 0), 1, st_of(0, 0, 0, 3, 1, 0)});
    dir_rows.push_back('{mk(REQ_TICK, 25'd10, 0, 0, 0), 1, st_of(0, 0, 0, 3, 0, 0)});
    dir_rows.push_back('{mk(REQ_START, 0, 24'd300, 8'd4, 0), 0, none});
    dir_rows.push_back('{mk(REQ_QUEUE, 0, 24'd200, 8'd9, 16'd100), 0, none});
    dir_rows.push_back('{mk(REQ_TICK, 25'h1ffff00, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_PAUSE, 0, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_PLAY, 0, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_TICK, 25'd500, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(REQ_STOP, 0, 0, 0, 0), 1, st_of(0, 0, 0, 4, 0, 0)});
    dir_rows.push_back('{mk(3'd7, 25'd5, 24'd5, 8'd5, 16'd5), 1, st_of(0, 0, 0, 4, 0, 0)});
    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].st);
    drain();

    // Directed again in loop mode with a negative rate, near promotion.
    write_cfg(CFG_LOOP_MODE, 16'd1);
    write_cfg(CFG_PLAY_RATE, 16'hf000);
    send_request(mk(REQ_START, 0, 24'd1000, 8'd1, 0), 0, none);
    send_request(mk(REQ_QUEUE, 0, 24'd700, 8'd2, 16'd40000), 0, none);
    send_request(mk(REQ_TICK, 25'd300, 0, 0, 0), 0, none);
    send_request(mk(REQ_SEEK, 25'h1fffff0, 0, 0, 0), 0, none);
    send_request(mk(REQ_TICK, 25'd7000, 0, 0, 0), 0, none);
    send_request(mk(REQ_TICK, 25'd7000, 0, 0, 0), 0, none);
    drain();

    // Random sessions under changing settings.
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_PLAY_RATE, ph < 6 ? rates[ph] : 16'($urandom));
      write_cfg(CFG_LOOP_MODE, 16'(ph % 2));
      for (int k = 0; k < 108; k++) begin
        rq = rand_request($urandom_range(0, 9) != 0, 8'd6);
        send_request(rq, 0, none);
      end
      drain();
    end

    drain();
    if (!failed && status_q.size() == 0) begin
      $display("animation_playhead_crossfade_core test passed");
    end else begin
      $display("animation_playhead_crossfade_core test failed");
    end
    $finish;
  end

endmodule
